// ===== design/lvi_pkg.sv =====
// Shared types, constants and the coefficient table of the vertical 8-tap luma filter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package lvi_pkg;

  localparam int unsigned LANES_MAX = 8;   // columns carried by one beat
  localparam int unsigned TAPS      = 8;
  localparam int unsigned HELD      = TAPS - 1;
  localparam int unsigned PIX_W     = 8;
  localparam int unsigned COEF_W    = 8;
  localparam int unsigned SUM_W     = 16;  // holds any weighted sum of 8-bit pixels
  localparam int unsigned ROUND     = 32;
  localparam int unsigned SHIFT     = 6;
  localparam int unsigned HELD_W    = $clog2(HELD + 1);
  localparam int unsigned PHASE_W   = 2;
  localparam int unsigned APB_AW    = 2;
  localparam int unsigned APB_DW    = 32;

  localparam logic [APB_AW-1:0] ADDR_PHASE = 2'd0;

  localparam logic signed [COEF_W-1:0] COEF [4][TAPS] = '{
    '{8'sd0,  8'sd0, 8'sd0,   8'sd64, 8'sd0,  8'sd0,   8'sd0, 8'sd0},
    '{-8'sd1, 8'sd4, -8'sd10, 8'sd58, 8'sd17, -8'sd5,  8'sd1, 8'sd0},
    '{-8'sd1, 8'sd4, -8'sd11, 8'sd40, 8'sd40, -8'sd11, 8'sd4, -8'sd1},
    '{8'sd0,  8'sd1, -8'sd5,  8'sd17, 8'sd58, -8'sd10, 8'sd4, -8'sd1}
  };

  typedef struct packed {
    logic             first_row;
    logic [PIX_W-1:0] pixel_0;
    logic [PIX_W-1:0] pixel_1;
    logic [PIX_W-1:0] pixel_2;
    logic [PIX_W-1:0] pixel_3;
    logic [PIX_W-1:0] pixel_4;
    logic [PIX_W-1:0] pixel_5;
    logic [PIX_W-1:0] pixel_6;
    logic [PIX_W-1:0] pixel_7;
  } in_beat_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_0;
    logic [PIX_W-1:0] out_1;
    logic [PIX_W-1:0] out_2;
    logic [PIX_W-1:0] out_3;
    logic [PIX_W-1:0] out_4;
    logic [PIX_W-1:0] out_5;
    logic [PIX_W-1:0] out_6;
    logic [PIX_W-1:0] out_7;
  } out_beat_t;

  typedef logic [PIX_W-1:0] pix_t;

endpackage

`default_nettype wire

// ===== design/lvi_window.sv =====
// Row window: shift line of the last HELD source rows and the fill counter.
// Depends on lvi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lvi_window
  import lvi_pkg::*;
#(
  parameter int unsigned LANES = LANES_MAX
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        accept_i,
  input  wire logic                        first_row_i,
  input  wire logic [LANES-1:0][PIX_W-1:0] row_i,
  output logic [HELD-1:0][LANES-1:0][PIX_W-1:0] rows_o,
  output logic                             produce_o
);

  logic [HELD-1:0][LANES-1:0][PIX_W-1:0] rows_q;
  logic [HELD_W-1:0]                     held_q, held_d;

  // A flagged row empties the window first, so it never yields a result.
  assign produce_o = !first_row_i && (held_q == HELD_W'(HELD));
  assign rows_o    = rows_q;

  always_comb begin
    held_d = held_q;
    if (first_row_i) begin
      held_d = HELD_W'(1);
    end else if (held_q != HELD_W'(HELD)) begin
      held_d = held_q + HELD_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      rows_q <= '0;
    end else if (accept_i) begin
      held_q <= held_d;
      // Advance: entry 0 is the oldest row.
      for (int k = 0; k < HELD - 1; k++) begin
        rows_q[k] <= rows_q[k+1];
      end
      rows_q[HELD-1] <= row_i;
    end
  end

endmodule

`default_nettype wire

// ===== design/lvi_lane.sv =====
// One column of the filter: eight weighted taps, rounding shift and clamp to 0..255.
// Depends on lvi_pkg for the coefficient table and widths.
`timescale 1ns / 1ps
`default_nettype none

module lvi_lane
  import lvi_pkg::*;
(
  input  wire logic [PHASE_W-1:0]        phase_i,
  input  wire logic [HELD-1:0][PIX_W-1:0] held_i,
  input  wire logic [PIX_W-1:0]           pix_i,
  output logic [PIX_W-1:0]                res_o
);

  logic [TAPS-1:0][PIX_W-1:0] tap_pix;
  logic signed [SUM_W-1:0]    prod [TAPS];
  logic signed [SUM_W-1:0]    sum;
  logic signed [SUM_W-1:0]    rnd;
  logic signed [SUM_W-1:0]    quo;

  assign tap_pix = {pix_i, held_i};

  always_comb begin
    for (int k = 0; k < TAPS; k++) begin
      prod[k] = $signed({{(SUM_W-PIX_W){1'b0}}, tap_pix[k]})
              * $signed({{(SUM_W-COEF_W){COEF[phase_i][k][COEF_W-1]}}, COEF[phase_i][k]});
    end
  end

  always_comb begin
    sum = '0;
    for (int k = 0; k < TAPS; k++) begin
      sum = sum + prod[k];
    end
  end

  assign rnd = sum + SUM_W'(ROUND);
  assign quo = rnd >>> SHIFT;

  always_comb begin
    if (rnd[SUM_W-1]) begin
      res_o = '0;
    end else if (|quo[SUM_W-1:PIX_W]) begin
      res_o = '1;
    end else begin
      res_o = quo[PIX_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== design/luma_vertical_8tap_interp.sv =====
// Vertical 8-tap luma interpolation filter: one row of pixels per beat, LANES columns.
// Throughput: one row per cycle while the skid entry is empty. The per-column tap sum
// settles in the accepting cycle and the result is registered into the output stage.
// A two-entry output stage (register plus skid) keeps input ready while a result waits.
// Reset clears the window, the fill count, the output stage and phase (copy).
// Depends on lvi_pkg, lvi_window and lvi_lane.
`timescale 1ns / 1ps
`default_nettype none

module luma_vertical_8tap_interp
  import lvi_pkg::*;
#(
  parameter int unsigned LANES = LANES_MAX
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire in_beat_t          in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output out_beat_t              out_data_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready
);

  logic [PHASE_W-1:0]              phase_q;
  logic                            accept;
  logic                            produce;
  logic                            push;
  logic                            pop;
  pix_t                            pix_all [LANES_MAX];
  pix_t                            res_all [LANES_MAX];
  logic [LANES-1:0][PIX_W-1:0]     row;
  logic [LANES-1:0][PIX_W-1:0]     lane_res;
  logic [HELD-1:0][LANES-1:0][PIX_W-1:0] rows;
  out_beat_t                       res_beat;
  out_beat_t                       out_q, skid_q;
  logic                            out_valid_q, skid_valid_q;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_PHASE) ? APB_DW'(phase_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (psel && penable && pwrite && pready && (paddr == ADDR_PHASE)) begin
      phase_q <= pwdata[PHASE_W-1:0];
    end
  end

  // Input row
  assign in_ready_o = !skid_valid_q;
  assign accept     = in_valid_i && in_ready_o;

  assign pix_all[0] = in_data_i.pixel_0;
  assign pix_all[1] = in_data_i.pixel_1;
  assign pix_all[2] = in_data_i.pixel_2;
  assign pix_all[3] = in_data_i.pixel_3;
  assign pix_all[4] = in_data_i.pixel_4;
  assign pix_all[5] = in_data_i.pixel_5;
  assign pix_all[6] = in_data_i.pixel_6;
  assign pix_all[7] = in_data_i.pixel_7;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      row[l] = pix_all[l];
    end
  end

  lvi_window #(
    .LANES(LANES)
  ) u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .first_row_i(in_data_i.first_row),
    .row_i      (row),
    .rows_o     (rows),
    .produce_o  (produce)
  );

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [HELD-1:0][PIX_W-1:0] held;
    always_comb begin
      for (int k = 0; k < HELD; k++) begin
        held[k] = rows[k][l];
      end
    end
    lvi_lane u_lane (
      .phase_i(phase_q),
      .held_i (held),
      .pix_i  (row[l]),
      .res_o  (lane_res[l])
    );
  end

  // Merge the lanes into one result beat; columns without a lane read zero.
  always_comb begin
    for (int c = 0; c < LANES_MAX; c++) begin
      res_all[c] = '0;
    end
    for (int l = 0; l < LANES; l++) begin
      res_all[l] = lane_res[l];
    end
  end

  assign res_beat = '{out_0: res_all[0], out_1: res_all[1], out_2: res_all[2],
                      out_3: res_all[3], out_4: res_all[4], out_5: res_all[5],
                      out_6: res_all[6], out_7: res_all[7]};

  // Output register with skid entry
  assign push = accept && produce;
  assign pop  = out_valid_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push) begin
      out_valid_q <= 1'b1;
      if (out_valid_q && !pop) begin
        skid_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push) begin
      if (!out_valid_q || pop) begin
        out_q <= res_beat;
      end else begin
        skid_q <= res_beat;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held while output register empty");

  a_stall_only_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && skid_valid_q))
    else $error("input stalled without a pending result");

  a_result_follows_push : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> out_valid_o)
    else $error("produced row did not reach the output");

  a_waiting_result_kept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("pending result changed or dropped");

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking bench for luma_vertical_8tap_interp: random and directed pixel rows
// under valid/ready flow control, with phase changes over APB. Depends on lvi_pkg.
// Expected rows come from an in-bench model of the vertical 8-tap window filter.
`timescale 1ns / 1ps

module tb_top;
  import lvi_pkg::*;

  localparam int NUM_MIXES = 5;
  localparam int ROWS_PER_MIX = 280;
  localparam int WIN_DEPTH = 7;
  localparam int DRAIN_LIMIT = 4000;

  // Fractional-position tap sets, oldest row first.
  localparam int FILT_TAPS [4][8] = '{
    '{ 0, 0,   0, 64,  0,   0, 0,  0},
    '{-1, 4, -10, 58, 17,  -5, 1,  0},
    '{-1, 4, -11, 40, 40, -11, 4, -1},
    '{ 0, 1,  -5, 17, 58, -10, 4, -1}
  };

  typedef pix_t lane_vec_t [8];

  logic clk = 1'b0;
  logic rst_ni = 1'b0;

  logic in_valid = 1'b0;
  in_beat_t in_data = '0;
  logic in_ready;
  logic out_valid;
  logic out_ready = 1'b0;
  out_beat_t out_data;

  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;

  in_beat_t row_queue[$];
  out_beat_t filtered_expect[$];

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  bit sender_hold = 1'b0;

  int unsigned err_count = 0;
  int unsigned rows_accepted = 0;
  int unsigned rows_checked = 0;

  // Model state
  pix_t win_rows [WIN_DEPTH][8];
  int unsigned rows_held = 0;
  logic [PHASE_W-1:0] filt_phase = '0;

  luma_vertical_8tap_interp dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #4 clk = ~clk;

  function automatic lane_vec_t row_lanes(in_beat_t r);
    lane_vec_t v;
    v[0] = r.pixel_0; v[1] = r.pixel_1; v[2] = r.pixel_2; v[3] = r.pixel_3;
    v[4] = r.pixel_4; v[5] = r.pixel_5; v[6] = r.pixel_6; v[7] = r.pixel_7;
    return v;
  endfunction

  function automatic lane_vec_t result_lanes(out_beat_t r);
    lane_vec_t v;
    v[0] = r.out_0; v[1] = r.out_1; v[2] = r.out_2; v[3] = r.out_3;
    v[4] = r.out_4; v[5] = r.out_5; v[6] = r.out_6; v[7] = r.out_7;
    return v;
  endfunction

  function automatic in_beat_t make_row(bit first, lane_vec_t v);
    in_beat_t r;
    r.first_row = first;
    r.pixel_0 = v[0]; r.pixel_1 = v[1]; r.pixel_2 = v[2]; r.pixel_3 = v[3];
    r.pixel_4 = v[4]; r.pixel_5 = v[5]; r.pixel_6 = v[6]; r.pixel_7 = v[7];
    return r;
  endfunction

  function automatic pix_t round_clamp(int sum);
    int s;
    s = sum + 32;
    if (s < 0) return 8'd0;
    s = s >>> 6;
    return (s > 255) ? 8'd255 : pix_t'(s);
  endfunction

  // Filter one accepted row against the window, then shift it in.
  function automatic void filter_row(in_beat_t r);
    lane_vec_t px;
    lane_vec_t res;
    int sum;
    px = row_lanes(r);
    if (r.first_row) rows_held = 0;
    if (rows_held >= WIN_DEPTH) begin
      for (int c = 0; c < 8; c++) begin
        sum = 0;
        for (int k = 0; k < WIN_DEPTH; k++)
          sum += int'(win_rows[k][c]) * FILT_TAPS[filt_phase][k];
        sum += int'(px[c]) * FILT_TAPS[filt_phase][WIN_DEPTH];
        res[c] = round_clamp(sum);
      end
      filtered_expect.push_back({res[0], res[1], res[2], res[3],
                                 res[4], res[5], res[6], res[7]});
    end
    for (int k = 0; k < WIN_DEPTH - 1; k++)
      for (int c = 0; c < 8; c++) win_rows[k][c] = win_rows[k + 1][c];
    for (int c = 0; c < 8; c++) win_rows[WIN_DEPTH - 1][c] = px[c];
    if (rows_held < WIN_DEPTH) rows_held++;
  endfunction

  task automatic report_mismatch(string msg);
    err_count++;
    $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // Driver: offer the next pending row, hold it until the beat is taken.
  always @(posedge clk) begin
    if (!in_valid || in_ready) begin
      if (rst_ni && row_queue.size() != 0 && !sender_hold &&
          $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= row_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Input monitor: every accepted beat advances the model.
  always @(posedge clk) begin
    if (rst_ni && in_valid && in_ready) begin
      filter_row(in_data);
      rows_accepted++;
    end
  end

  // Output monitor: compare each result beat with the oldest expectation.
  always @(posedge clk) begin
    lane_vec_t got;
    lane_vec_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (filtered_expect.size() == 0) begin
        report_mismatch($sformatf("unexpected result beat %h", out_data));
      end else begin
        got = result_lanes(out_data);
        want = result_lanes(filtered_expect.pop_front());
        for (int c = 0; c < 8; c++)
          if (got[c] !== want[c])
            report_mismatch($sformatf("row %0d out_%0d got %0d want %0d",
                                      rows_checked, c, got[c], want[c]));
        rows_checked++;
      end
    end
  end

  function automatic pix_t random_pixel();
    case ($urandom_range(7))
      0: return 8'd0;
      1: return 8'd255;
      default: return pix_t'($urandom_range(255));
    endcase
  endfunction

  function automatic in_beat_t random_row();
    lane_vec_t v;
    for (int c = 0; c < 8; c++) v[c] = random_pixel();
    return make_row($urandom_range(19) == 0, v);
  endfunction

  task automatic wait_drained();
    while (row_queue.size() != 0 || in_valid || filtered_expect.size() != 0)
      @(posedge clk);
    // let the output stage settle before touching the register
    repeat (4) @(posedge clk);
  endtask

  task automatic write_phase(logic [PHASE_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_PHASE;
    pwdata <= APB_DW'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    filt_phase = value;
  endtask

  initial begin
    int unsigned mix_phase [NUM_MIXES] = '{3, 1, 0, 2, 3};
    int unsigned mix_idle [NUM_MIXES] = '{0, 55, 0, 34, 0};
    int unsigned mix_stall [NUM_MIXES] = '{0, 0, 55, 34, 0};
    lane_vec_t v;
    int unsigned waited;

    repeat (7) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // Saturated rows under the reset (copy) phase, then a zero row.
    for (int c = 0; c < 8; c++) v[c] = 8'd255;
    for (int k = 0; k < 8; k++) row_queue.push_back(make_row(k == 0, v));
    for (int c = 0; c < 8; c++) v[c] = 8'd0;
    row_queue.push_back(make_row(1'b0, v));
    wait_drained();

    // Half phase: even columns overflow past 255, odd columns go negative.
    write_phase(2'd2);
    for (int k = 0; k < 9; k++) begin
      for (int c = 0; c < 8; c++)
        v[c] = ((FILT_TAPS[2][k % 8] > 0) ^ c[0]) ? 8'd255 : 8'd0;
      row_queue.push_back(make_row(k == 0, v));
    end
    // Restart the window and send too few rows to fill it.
    for (int k = 0; k < 3; k++) begin
      for (int c = 0; c < 8; c++) v[c] = pix_t'(k * 80 + c);
      row_queue.push_back(make_row(k == 0, v));
    end
    row_queue.push_back(random_row());
    wait_drained();

    for (int m = 0; m < NUM_MIXES; m++) begin
      write_phase(mix_phase[m][PHASE_W-1:0]);
      send_idle_pct = mix_idle[m];
      stall_pct = mix_stall[m];
      for (int n = 0; n < ROWS_PER_MIX; n++) begin
        row_queue.push_back(random_row());
        if (m == 3 && n == ROWS_PER_MIX / 2) begin
          // hold the sender until every pending result is out
          while (row_queue.size() != 0 || in_valid) @(posedge clk);
          sender_hold = 1'b1;
          while (filtered_expect.size() != 0) @(posedge clk);
          sender_hold = 1'b0;
        end
      end
      wait_drained();
    end

    send_idle_pct = 0;
    stall_pct = 0;
    while (row_queue.size() != 0 || in_valid) @(posedge clk);
    waited = 0;
    while (filtered_expect.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (filtered_expect.size() != 0)
      report_mismatch($sformatf("%0d expected rows never came out",
                                filtered_expect.size()));

    $display("Covered %0d source rows and %0d filtered rows over all four phases,",
             rows_accepted, rows_checked);
    $display("with window restarts, clamp extremes and five flow-control mixes.");
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout with %0d rows still expected.", filtered_expect.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
